FILE: rtl/swtq_pkg.sv
// ----------------------------------------------------------------------------
// swtq_pkg
// Types, constants and helpers shared by the sorted wakeup timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package swtq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [ADDR_W:0]   count_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam count_t DEPTH_C = count_t'(QUEUE_DEPTH);
    localparam cnt_t   MAX_C   = cnt_t'(MAX_RESULTS);
    localparam addr_t  LAST_A  = addr_t'(QUEUE_DEPTH - 1);

    // Input kinds
    localparam logic KIND_SLEEP = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_ZERO     = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_TICK     = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_REPLY,
        S_TICK_RD,
        S_TICK_CMP,
        S_TICK_FIN
    } state_t;

    // One queue entry as stored in memory
    typedef struct packed {
        logic [63:0] wake;
        logic [7:0]  id;
        logic [5:0]  prio;
    } entry_t;

    // Input transaction payload
    typedef struct packed {
        logic        kind;
        logic [7:0]  sleeper_id;
        logic [31:0] sleep_duration;
        logic [5:0]  sleeper_priority;
        logic [5:0]  running_priority;
    } req_t;

    // Result transaction payload
    typedef struct packed {
        status_t    status;
        logic       woken_valid;
        logic [7:0] woken_id;
        logic       yield_request;
        logic       last;
    } res_t;

    // Memory access request from the controller
    typedef struct packed {
        logic   rd_en;
        addr_t  rd_addr;
        logic   wr_en;
        addr_t  wr_addr;
        entry_t wr_data;
    } mem_req_t;

    // Map a queue position (relative to head) onto a memory address
    function automatic addr_t phys_addr(addr_t base, count_t offs);
        count_t sum;
        sum = count_t'(base) + offs;
        if (sum >= DEPTH_C) begin
            sum = sum - DEPTH_C;
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Advance the head pointer around the ring
    function automatic addr_t next_addr(addr_t a);
        return (a == LAST_A) ? '0 : a + addr_t'(1);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/swtq_req_if.sv
// ----------------------------------------------------------------------------
// swtq_req_if
// Request channel: sleep requests and timer ticks with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface swtq_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  sleeper_id;
    logic [31:0] sleep_duration;
    logic [5:0]  sleeper_priority;
    logic [5:0]  running_priority;

    modport source (
        output valid, kind, sleeper_id, sleep_duration, sleeper_priority,
               running_priority,
        input  ready
    );

    modport sink (
        input  valid, kind, sleeper_id, sleep_duration, sleeper_priority,
               running_priority,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/swtq_rsp_if.sv
// ----------------------------------------------------------------------------
// swtq_rsp_if
// Result channel: insert status and woken sleepers with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface swtq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       woken_valid;
    logic [7:0] woken_id;
    logic       yield_request;
    logic       last;

    modport source (
        output valid, status, woken_valid, woken_id, yield_request, last,
        input  ready
    );

    modport sink (
        input  valid, status, woken_valid, woken_id, yield_request, last,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/swtq_store.sv
// ----------------------------------------------------------------------------
// swtq_store
// Entry memory of the queue: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swtq_store (
    input  wire logic              clk,
    input  wire swtq_pkg::mem_req_t mem,
    output swtq_pkg::entry_t       rd_data
);
    import swtq_pkg::*;

    entry_t mem_array [QUEUE_DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem.wr_en)
        begin
            mem_array[mem.wr_addr] <= mem.wr_data;
        end
    end

    // Read port: data holds until the next read
    always_ff @(posedge clk)
    begin
        if (mem.rd_en)
        begin
            rd_data_reg <= mem_array[mem.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/swtq_ctrl.sv
// ----------------------------------------------------------------------------
// swtq_ctrl
// Sequencer: tick counter, ring pointers, sorted insert and expiry walk.
// ----------------------------------------------------------------------------
`default_nettype none

module swtq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire swtq_pkg::req_t    in_data,
    output logic                   res_valid,
    output swtq_pkg::res_t         res_data,
    input  wire logic              out_free,
    output swtq_pkg::mem_req_t     mem,
    input  wire swtq_pkg::entry_t  rd_data
);
    import swtq_pkg::*;

    state_t      state_reg,  state_next;
    logic [63:0] tick_reg,   tick_next;
    count_t      occ_reg,    occ_next;
    addr_t       head_reg,   head_next;
    count_t      idx_reg,    idx_next;
    cnt_t        cnt_reg,    cnt_next;
    logic        pend_reg,   pend_next;
    logic        yield_reg,  yield_next;
    status_t     status_reg, status_next;
    logic [63:0] wake_reg,   wake_next;
    logic [7:0]  id_reg,     id_next;
    logic [5:0]  prio_reg,   prio_next;
    logic [5:0]  run_reg,    run_next;
    logic [7:0]  pid_reg,    pid_next;

    entry_t new_entry;
    logic   due;

    assign new_entry = '{wake: wake_reg, id: id_reg, prio: prio_reg};
    assign due       = (rd_data.wake <= tick_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tick_reg   <= '0;
            occ_reg    <= '0;
            head_reg   <= '0;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            yield_reg  <= 1'b0;
            status_reg <= STATUS_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            occ_reg    <= occ_next;
            head_reg   <= head_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            yield_reg  <= yield_next;
            status_reg <= status_next;
        end
    end

    // Captured request payload
    always_ff @(posedge clk)
    begin
        wake_reg <= wake_next;
        id_reg   <= id_next;
        prio_reg <= prio_next;
        run_reg  <= run_next;
        pid_reg  <= pid_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        occ_next    = occ_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        yield_next  = yield_reg;
        status_next = status_reg;
        wake_next   = wake_reg;
        id_next     = id_reg;
        prio_next   = prio_reg;
        run_next    = run_reg;
        pid_next    = pid_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        res_data    = '0;
        mem         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.kind == KIND_TICK)
                    begin
                        // advance time, then walk the expired head entries
                        tick_next  = tick_reg + 64'd1;
                        run_next   = in_data.running_priority;
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        yield_next = 1'b0;
                        state_next = S_TICK_RD;
                    end
                    else
                    begin
                        id_next   = in_data.sleeper_id;
                        prio_next = in_data.sleeper_priority;
                        wake_next = tick_reg + 64'(in_data.sleep_duration);
                        idx_next  = occ_reg;
                        if (in_data.sleep_duration == 32'd0)
                        begin
                            status_next = STATUS_ZERO;
                            state_next  = S_REPLY;
                        end
                        else if (occ_reg == DEPTH_C)
                        begin
                            status_next = STATUS_FULL;
                            state_next  = S_REPLY;
                        end
                        else
                        begin
                            status_next = STATUS_INSERTED;
                            state_next  = S_INS_RD;
                        end
                    end
                end
            end

            S_INS_RD:
            begin
                // hole reached the front: place the new entry there
                if (idx_reg == '0)
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = phys_addr(head_reg, idx_reg);
                    mem.wr_data = new_entry;
                    occ_next    = occ_reg + count_t'(1);
                    state_next  = S_REPLY;
                end
                else
                begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = phys_addr(head_reg, idx_reg - count_t'(1));
                    state_next  = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = phys_addr(head_reg, idx_reg);
                // shift later entries up; equal wake times stay ahead
                if (rd_data.wake > wake_reg)
                begin
                    mem.wr_data = rd_data;
                    idx_next    = idx_reg - count_t'(1);
                    state_next  = S_INS_RD;
                end
                else
                begin
                    mem.wr_data = new_entry;
                    occ_next    = occ_reg + count_t'(1);
                    state_next  = S_REPLY;
                end
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    res_valid       = 1'b1;
                    res_data.status = status_reg;
                    res_data.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_TICK_RD:
            begin
                if ((occ_reg != '0) && (cnt_reg < MAX_C))
                begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = head_reg;
                    state_next  = S_TICK_CMP;
                end
                else
                begin
                    state_next = S_TICK_FIN;
                end
            end

            S_TICK_CMP:
            begin
                if (!due)
                begin
                    state_next = S_TICK_FIN;
                end
                else if (!pend_reg || out_free)
                begin
                    // release the held sleeper, hold the new one
                    if (pend_reg)
                    begin
                        res_valid            = 1'b1;
                        res_data.status      = STATUS_TICK;
                        res_data.woken_valid = 1'b1;
                        res_data.woken_id    = pid_reg;
                    end
                    pend_next = 1'b1;
                    pid_next  = rd_data.id;
                    if (rd_data.prio > run_reg)
                    begin
                        yield_next = 1'b1;
                    end
                    head_next  = next_addr(head_reg);
                    occ_next   = occ_reg - count_t'(1);
                    cnt_next   = cnt_reg + cnt_t'(1);
                    state_next = S_TICK_RD;
                end
            end

            S_TICK_FIN:
            begin
                if (out_free)
                begin
                    res_valid              = 1'b1;
                    res_data.status        = STATUS_TICK;
                    res_data.woken_valid   = pend_reg;
                    res_data.woken_id      = pend_reg ? pid_reg : 8'd0;
                    res_data.yield_request = pend_reg & yield_reg;
                    res_data.last          = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Occupancy never exceeds the ring size
    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= DEPTH_C)
        else $error("swtq_ctrl: occupancy above queue depth");

    // A result is only offered when the output stage can take it
    assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> out_free)
        else $error("swtq_ctrl: result offered into a full output stage");

    // Read and write ports are never used in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(mem.rd_en && mem.wr_en))
        else $error("swtq_ctrl: memory read and write overlap");

    // An accepted tick advances the counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.kind == KIND_TICK)
        |=> (tick_reg == $past(tick_reg) + 64'd1))
        else $error("swtq_ctrl: tick counter did not advance");

    // The wake walk stops at the per-tick result limit
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= MAX_C)
        else $error("swtq_ctrl: woken count above limit");

endmodule

`default_nettype wire

FILE: rtl/sorted_wakeup_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_wakeup_timer_queue
// Tick counter with a wake-time ordered queue of sleepers.
// ----------------------------------------------------------------------------
// Usage:
//   req carries sleep requests (kind 0) and timer ticks (kind 1); rsp carries
//   results. Both use valid/ready; a transaction moves when both are high.
//   A sleep request gives one result: inserted, zero duration or queue full.
//   A tick gives one result per woken sleeper (up to MAX_RESULTS), or one
//   empty result; the final result carries last and yield_request.
//   Flow: a request is taken only while the sequencer is idle. Zero
//   duration or full queue goes straight to the reply; an insert reads each
//   later entry and writes it back one place through the one memory, then
//   writes the new entry into the hole that is left.
//   A tick reads and compares the head entry one at a time and stops at the
//   result limit, on an empty queue or on a head entry that is not yet due.
//   Results leave through an output register; when the receiver stalls the
//   sequencer holds its current step until the register is free.
//   Reset clears the tick counter and empties the queue at once; the entry
//   memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_wakeup_timer_queue (
    input  wire logic     clk,
    input  wire logic     rst_n,
    swtq_req_if.sink      req,
    swtq_rsp_if.source    rsp
);
    import swtq_pkg::*;

    req_t     in_data;
    logic     in_ready;
    logic     res_valid;
    res_t     res_data;
    logic     out_free;
    mem_req_t mem;
    entry_t   rd_data;

    logic     rsp_valid_reg;
    res_t     rsp_data_reg;

    // Gather request fields
    assign in_data = '{kind:             req.kind,
                       sleeper_id:       req.sleeper_id,
                       sleep_duration:   req.sleep_duration,
                       sleeper_priority: req.sleeper_priority,
                       running_priority: req.running_priority};
    assign req.ready = in_ready;

    swtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_data  (res_data),
        .out_free  (out_free),
        .mem       (mem),
        .rd_data   (rd_data)
    );

    swtq_store u_store (
        .clk     (clk),
        .mem     (mem),
        .rd_data (rd_data)
    );

    // Output register: free when empty or draining this cycle
    assign out_free = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_data_reg <= res_data;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_data_reg.status;
    assign rsp.woken_valid   = rsp_data_reg.woken_valid;
    assign rsp.woken_id      = rsp_data_reg.woken_id;
    assign rsp.yield_request = rsp_data_reg.yield_request;
    assign rsp.last          = rsp_data_reg.last;

endmodule

`default_nettype wire

FILE: tb/sv/sorted_wakeup_timer_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_wakeup_timer_queue_tb
// Self-checking testbench for the sorted wakeup timer queue. It drives sleep
// requests and timer ticks under random stalls on both channels and checks
// every result against an in-line model of the tick counter and the queue.
// ----------------------------------------------------------------------------
module sorted_wakeup_timer_queue_tb;
    import swtq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    swtq_req_if req ();
    swtq_rsp_if rsp ();

    sorted_wakeup_timer_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Model of the tick counter and the sleeper queue
    logic [63:0] now_ticks = '0;
    logic [63:0] wake_at    [QUEUE_DEPTH];
    logic [7:0]  sleeper_of [QUEUE_DEPTH];
    logic [5:0]  prio_of    [QUEUE_DEPTH];
    int          sleepers = 0;
    res_t        pending_results [$];

    int send_idle_pct = 27;
    int recv_idle_pct = 77;
    int mismatches    = 0;
    int cycles        = 0;

    always #1 clk = ~clk;

    function automatic res_t make_result(status_t st, logic woke, logic [7:0] id,
                                         logic yld, logic fin);
        res_t r;
        r.status        = st;
        r.woken_valid   = woke;
        r.woken_id      = id;
        r.yield_request = yld;
        r.last          = fin;
        return r;
    endfunction

    // Update the queue model for one accepted transaction and queue its results
    function automatic void predict_outcome(input req_t r);
        logic [63:0] wake;
        int          pos;
        int          woken;
        logic        yld;
        if (r.kind == KIND_SLEEP) begin
            if (r.sleep_duration == 32'd0) begin
                pending_results.push_back(make_result(STATUS_ZERO, 1'b0, 8'd0, 1'b0, 1'b1));
            end
            else if (sleepers >= QUEUE_DEPTH) begin
                pending_results.push_back(make_result(STATUS_FULL, 1'b0, 8'd0, 1'b0, 1'b1));
            end
            else begin
                // Insert after every entry waking at the same time or earlier
                wake = now_ticks + 64'(r.sleep_duration);
                pos  = 0;
                while (pos < sleepers && wake_at[pos] <= wake) begin
                    pos++;
                end
                for (int k = sleepers; k > pos; k--) begin
                    wake_at[k]    = wake_at[k-1];
                    sleeper_of[k] = sleeper_of[k-1];
                    prio_of[k]    = prio_of[k-1];
                end
                wake_at[pos]    = wake;
                sleeper_of[pos] = r.sleeper_id;
                prio_of[pos]    = r.sleeper_priority;
                sleepers++;
                pending_results.push_back(make_result(STATUS_INSERTED, 1'b0, 8'd0, 1'b0, 1'b1));
            end
        end
        else begin
            // Advance the counter, then pop due sleepers from the head, up to MAX_RESULTS
            now_ticks = now_ticks + 64'd1;
            woken     = 0;
            yld       = 1'b0;
            while (woken < sleepers && woken < MAX_RESULTS && wake_at[woken] <= now_ticks) begin
                if (prio_of[woken] > r.running_priority) begin
                    yld = 1'b1;
                end
                woken++;
            end
            if (woken == 0) begin
                pending_results.push_back(make_result(STATUS_TICK, 1'b0, 8'd0, 1'b0, 1'b1));
            end
            else begin
                for (int k = 0; k < woken; k++) begin
                    pending_results.push_back(make_result(STATUS_TICK, 1'b1, sleeper_of[k],
                                                          (k == woken - 1) ? yld : 1'b0,
                                                          k == woken - 1));
                end
                for (int k = 0; k + woken < sleepers; k++) begin
                    wake_at[k]    = wake_at[k+woken];
                    sleeper_of[k] = sleeper_of[k+woken];
                    prio_of[k]    = prio_of[k+woken];
                end
                sleepers = sleepers - woken;
            end
        end
    endfunction

    function automatic req_t sleep_item(logic [7:0] id, logic [31:0] dur, logic [5:0] prio);
        req_t r;
        r.kind             = KIND_SLEEP;
        r.sleeper_id       = id;
        r.sleep_duration   = dur;
        r.sleeper_priority = prio;
        r.running_priority = 6'($urandom_range(63));
        return r;
    endfunction

    function automatic req_t tick_item(logic [5:0] run_prio);
        req_t r;
        r.kind             = KIND_TICK;
        r.sleeper_id       = 8'($urandom_range(255));
        r.sleep_duration   = $urandom;
        r.sleeper_priority = 6'($urandom_range(63));
        r.running_priority = run_prio;
        return r;
    endfunction

    function automatic req_t random_request(input int tick_pct);
        req_t r;
        int   pick;
        r.kind             = ($urandom_range(99) < tick_pct) ? KIND_TICK : KIND_SLEEP;
        r.sleeper_id       = 8'($urandom_range(255));
        r.sleeper_priority = 6'($urandom_range(63));
        r.running_priority = 6'($urandom_range(63));
        pick               = $urandom_range(99);
        // Mostly short sleeps; far wake times stay queued, so keep them rare
        if (pick < 5) begin
            r.sleep_duration = 32'd0;
        end
        else if (pick < 7) begin
            r.sleep_duration = $urandom;
        end
        else begin
            r.sleep_duration = 32'($urandom_range(12, 1));
        end
        return r;
    endfunction

    // Drive one transaction at the falling edge and hold it until accepted
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            req.valid <= 1'b0;
        end
        @(negedge clk);
        req.valid            <= 1'b1;
        req.kind             <= r.kind;
        req.sleeper_id       <= r.sleeper_id;
        req.sleep_duration   <= r.sleep_duration;
        req.sleeper_priority <= r.sleeper_priority;
        req.running_priority <= r.running_priority;
        @(posedge clk);
        while (req.ready !== 1'b1) begin
            @(posedge clk);
        end
        predict_outcome(r);
    endtask

    // Toggle receiver back-pressure
    always @(negedge clk) begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin : check_results
        res_t want;
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("ERROR: unexpected result status=%0d woken=%0b id=%0d yield=%0b last=%0b",
                             rsp.status, rsp.woken_valid, rsp.woken_id, rsp.yield_request,
                             rsp.last);
                end
                mismatches++;
            end
            else begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status || rsp.woken_valid !== want.woken_valid ||
                    rsp.woken_id !== want.woken_id ||
                    rsp.yield_request !== want.yield_request || rsp.last !== want.last) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("ERROR: result mismatch at cycle %0d", cycles);
                        $display("  expected status=%0d woken=%0b id=%0d yield=%0b last=%0b",
                                 want.status, want.woken_valid, want.woken_id,
                                 want.yield_request, want.last);
                        $display("  actual   status=%0d woken=%0b id=%0d yield=%0b last=%0b",
                                 rsp.status, rsp.woken_valid, rsp.woken_id,
                                 rsp.yield_request, rsp.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Abort a hung run
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("sorted_wakeup_timer_queue test failed");
        $finish;
    end

    task automatic test_empty_tick();
        send_request(tick_item(6'd0));
    endtask

    task automatic test_zero_duration();
        send_request(sleep_item(8'hFF, 32'd0, 6'd63));
    endtask

    // Two sleepers due on the same tick; one outranks the running thread
    task automatic test_priority_yield();
        send_request(sleep_item(8'h00, 32'd1, 6'd0));
        send_request(sleep_item(8'hA5, 32'd1, 6'd41));
        send_request(tick_item(6'd40));
    endtask

    // Fill the queue with equal wake times, overflow it, then wake all at once
    task automatic test_fill_and_flush();
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            send_request(sleep_item(8'(k * 17), 32'd1, 6'(k * 4 + 3)));
        end
        send_request(sleep_item(8'h3C, 32'd7, 6'd5));
        send_request(tick_item(6'd63));
    endtask

    task automatic test_max_duration();
        send_request(sleep_item(8'hFF, 32'hFFFF_FFFF, 6'd63));
    endtask

    // Random mix; vary the tick rate in bursts to swing between full and empty
    task automatic test_random_traffic(input int items);
        int tick_pct;
        tick_pct = 35;
        for (int i = 0; i < items; i++) begin
            if (i % 20 == 0) begin
                case ($urandom_range(2))
                    0:       tick_pct = 15;
                    1:       tick_pct = 35;
                    default: tick_pct = 60;
                endcase
            end
            send_request(random_request(tick_pct));
        end
    endtask

    initial begin
        req.valid            = 1'b0;
        req.kind             = KIND_SLEEP;
        req.sleeper_id       = '0;
        req.sleep_duration   = '0;
        req.sleeper_priority = '0;
        req.running_priority = '0;
        rsp.ready            = 1'b0;

        // Hold reset, release on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_tick();
        test_zero_duration();
        test_priority_yield();
        test_fill_and_flush();
        test_max_duration();
        test_random_traffic(95);

        send_idle_pct = 77;
        recv_idle_pct = 27;
        test_random_traffic(95);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(95);

        // Drop valid, drain outstanding results, then settle
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("sorted_wakeup_timer_queue test passed");
        end
        else begin
            $display("sorted_wakeup_timer_queue test failed");
        end
        $finish;
    end

endmodule
